>>> sv/gnss_binary_frame_crc32_receiver_defines.svh
// Assertion macros shared by the receiver modules.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef GNSS_BINARY_FRAME_CRC32_RECEIVER_DEFINES_SVH
`define GNSS_BINARY_FRAME_CRC32_RECEIVER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Property that is checked at every clock edge outside reset.
`define GBFCR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Condition in one cycle that forces a consequence in the next cycle.
`define GBFCR_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) pre |=> post) else $error(msg);
`else
`define GBFCR_ASSERT(lbl, prop, msg)
`define GBFCR_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

>>> sv/gbfcr_pkg.sv
`default_nettype none

package gbfcr_pkg;

	// Default header length in bytes, sync bytes included.
	localparam int unsigned HEADER_BYTES_DEF = 28;

	// Frame offset width and the depth of the transaction queue.
	localparam int unsigned OffsetW = 17;
	localparam int unsigned QDepth = 2;

	// Reset value of the reflected CRC-32 polynomial.
	localparam logic [31:0] CrcPolyReset = 32'hEDB88320;

	// Sync sequence.
	localparam logic [7:0] Sync0 = 8'hAA;
	localparam logic [7:0] Sync1 = 8'h44;
	localparam logic [7:0] Sync2 = 8'h12;

	// Header offsets of the little-endian message ID and payload length.
	localparam logic [OffsetW-1:0] OffIdLo = 17'd4;
	localparam logic [OffsetW-1:0] OffIdHi = 17'd5;
	localparam logic [OffsetW-1:0] OffLenLo = 17'd8;
	localparam logic [OffsetW-1:0] OffLenHi = 17'd9;
	localparam logic [OffsetW-1:0] OffSync2 = 17'd2;
	localparam logic [OffsetW-1:0] OffFirstHdr = 17'd3;

	// Message IDs with a class of their own.
	localparam logic [15:0] IdRange = 16'd43;
	localparam logic [15:0] IdGpsEph = 16'd7;
	localparam logic [15:0] IdBdsEph = 16'd1696;
	localparam logic [15:0] IdPosition = 16'd42;

	// Message class codes.
	localparam logic [2:0] ClsRange = 3'd0;
	localparam logic [2:0] ClsGpsEph = 3'd1;
	localparam logic [2:0] ClsBdsEph = 3'd2;
	localparam logic [2:0] ClsPosition = 3'd3;
	localparam logic [2:0] ClsOther = 3'd4;

	// What the back end does with the CRC for one byte.
	typedef enum logic [1:0] {
		CRC_HOLD,
		CRC_RESTART,
		CRC_UPDATE,
		CRC_CHECK
	} crc_op_t;

	// One classified byte on its way from the front end to the back end.
	typedef struct packed {
		logic [7:0] data;
		logic in_frame;
		logic [OffsetW-1:0] offset;
		logic is_payload;
		logic done;
		logic [15:0] message_id;
		logic [15:0] payload_length;
		logic [2:0] message_class;
		crc_op_t crc_op;
		logic [1:0] crc_idx;
	} q_entry_t;

endpackage

`default_nettype wire

>>> sv/gbfcr_front.sv
`default_nettype none

`include "gnss_binary_frame_crc32_receiver_defines.svh"

module gbfcr_front #(
	parameter int unsigned HEADER_BYTES = gbfcr_pkg::HEADER_BYTES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [7:0] data_byte,
	input wire logic q_full,
	output logic push,
	output gbfcr_pkg::q_entry_t entry
);
	import gbfcr_pkg::*;

	typedef enum logic [1:0] {
		HUNT_IDLE,
		HUNT_AA,
		HUNT_AA44,
		IN_FRAME
	} phase_t;

	localparam logic [OffsetW-1:0] HdrLen = OffsetW'(HEADER_BYTES);

	phase_t phase_q, phase_d;
	logic [OffsetW-1:0] count_q, count_d;
	logic [15:0] id_q, id_d;
	logic [15:0] len_q, len_d;
	logic [OffsetW-1:0] pay_end;
	logic [1:0] crc_idx;

	function automatic logic [2:0] class_of(input logic [15:0] id);
		logic [2:0] cls;
		cls = ClsOther;
		if (id == IdRange) cls = ClsRange;
		else if (id == IdGpsEph) cls = ClsGpsEph;
		else if (id == IdBdsEph) cls = ClsBdsEph;
		else if (id == IdPosition) cls = ClsPosition;
		return cls;
	endfunction

	// A transaction is taken whenever the queue has room.
	assign in_stall = q_full;
	assign push = in_valid && !q_full;

	// End of the payload and the place of a byte inside the trailing CRC.
	assign pay_end = HdrLen + {1'b0, len_q};
	assign crc_idx = 2'(count_q[1:0] - pay_end[1:0]);

	// Classify the byte and work out the next framing state.
	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		id_d = id_q;
		len_d = len_q;
		entry = '0;
		entry.data = data_byte;
		entry.crc_op = CRC_HOLD;
		case (phase_q)
			IN_FRAME: begin
				entry.in_frame = 1'b1;
				entry.offset = count_q;
				if (count_q < HdrLen) begin
					if (count_q == OffIdLo) id_d = {id_q[15:8], data_byte};
					else if (count_q == OffIdHi) id_d = {data_byte, id_q[7:0]};
					else if (count_q == OffLenLo) len_d = {len_q[15:8], data_byte};
					else if (count_q == OffLenHi) len_d = {data_byte, len_q[7:0]};
					entry.crc_op = CRC_UPDATE;
					count_d = count_q + 1'b1;
				end else if (count_q < pay_end) begin
					entry.is_payload = 1'b1;
					entry.crc_op = CRC_UPDATE;
					count_d = count_q + 1'b1;
				end else begin
					entry.crc_op = CRC_CHECK;
					entry.crc_idx = crc_idx;
					if (crc_idx == 2'd3) begin
						entry.done = 1'b1;
						entry.message_id = id_q;
						entry.payload_length = len_q;
						entry.message_class = class_of(id_q);
						phase_d = HUNT_IDLE;
						count_d = '0;
					end else begin
						count_d = count_q + 1'b1;
					end
				end
			end
			default: begin
				if (phase_q == HUNT_AA44 && data_byte == Sync2) begin
					entry.in_frame = 1'b1;
					entry.offset = OffSync2;
					entry.crc_op = CRC_UPDATE;
					id_d = '0;
					len_d = '0;
					phase_d = IN_FRAME;
					count_d = OffFirstHdr;
				end else if (phase_q == HUNT_AA && data_byte == Sync1) begin
					entry.crc_op = CRC_UPDATE;
					phase_d = HUNT_AA44;
				end else if (data_byte == Sync0) begin
					entry.crc_op = CRC_RESTART;
					phase_d = HUNT_AA;
				end else begin
					phase_d = HUNT_IDLE;
				end
			end
		endcase
	end

	// Framing state advances on every accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= HUNT_IDLE;
			count_q <= '0;
			id_q <= '0;
			len_q <= '0;
		end else if (push) begin
			phase_q <= phase_d;
			count_q <= count_d;
			id_q <= id_d;
			len_q <= len_d;
		end
	end

	`GBFCR_ASSERT(a_frame_count, (phase_q == IN_FRAME) |-> (count_q >= OffFirstHdr), "frame offset below first header byte")
	`GBFCR_ASSERT_NEXT(a_sync_enter, push && phase_q == HUNT_AA44 && data_byte == Sync2, phase_q == IN_FRAME && count_q == OffFirstHdr, "sync did not open a frame")
	`GBFCR_ASSERT(a_report_only_done, (push && !entry.done) |-> (entry.message_id == 16'd0 && entry.message_class == 3'd0), "report fields set without frame end")

endmodule

`default_nettype wire

>>> sv/gbfcr_fifo.sv
`default_nettype none

`include "gnss_binary_frame_crc32_receiver_defines.svh"

module gbfcr_fifo (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire gbfcr_pkg::q_entry_t push_data,
	output logic full,
	input wire logic pop,
	output gbfcr_pkg::q_entry_t pop_data,
	output logic empty
);
	import gbfcr_pkg::*;

	localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int unsigned CntW = $clog2(QDepth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(QDepth - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(QDepth);

	q_entry_t data_q [QDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	assign full = (cnt_q == CntFull);
	assign empty = (cnt_q == '0);
	assign pop_data = data_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`GBFCR_ASSERT(a_cnt_range, cnt_q <= CntFull, "queue count above depth")

endmodule

`default_nettype wire

>>> sv/gbfcr_back.sv
`default_nettype none

`include "gnss_binary_frame_crc32_receiver_defines.svh"

module gbfcr_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic crc_polynomial_we,
	input wire logic [31:0] crc_polynomial,
	input wire logic q_empty,
	input wire gbfcr_pkg::q_entry_t q_data,
	output logic pop,
	output logic out_valid,
	input wire logic out_stall,
	output logic [7:0] echo_byte,
	output logic in_frame,
	output logic [gbfcr_pkg::OffsetW-1:0] frame_offset,
	output logic is_payload,
	output logic frame_done,
	output logic crc_ok,
	output logic [15:0] message_id,
	output logic [15:0] payload_length,
	output logic [2:0] message_class
);
	import gbfcr_pkg::*;

	logic [31:0] poly_q;
	logic [31:0] crc_q;
	logic [31:0] rcv_q;
	logic [31:0] crc_seed;
	logic [31:0] crc_next;
	logic ok_next;
	logic out_valid_q;
	logic [7:0] echo_byte_q;
	logic in_frame_q;
	logic [OffsetW-1:0] frame_offset_q;
	logic is_payload_q;
	logic frame_done_q;
	logic crc_ok_q;
	logic [15:0] message_id_q;
	logic [15:0] payload_length_q;
	logic [2:0] message_class_q;

	// Eight unrolled shift steps of the reflected CRC.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b,
			input logic [31:0] poly);
		logic [31:0] c;
		c = crc_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
		end
		return c;
	endfunction

	// Take a transaction when the output register is free or being emptied.
	assign pop = !q_empty && (!out_valid_q || !out_stall);

	assign crc_seed = (q_data.crc_op == CRC_RESTART) ? 32'd0 : crc_q;
	assign crc_next = crc_byte(crc_seed, q_data.data, poly_q);
	assign ok_next = q_data.done && ({q_data.data, rcv_q[23:0]} == crc_q);

	// Polynomial register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= CrcPolyReset;
		end else if (crc_polynomial_we) begin
			poly_q <= crc_polynomial;
		end
	end

	// Running and received CRC.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
			rcv_q <= '0;
		end else if (pop) begin
			case (q_data.crc_op)
				CRC_RESTART, CRC_UPDATE: crc_q <= crc_next;
				CRC_CHECK: rcv_q[{q_data.crc_idx, 3'b000} +: 8] <= q_data.data;
				default: ;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			echo_byte_q <= q_data.data;
			in_frame_q <= q_data.in_frame;
			frame_offset_q <= q_data.offset;
			is_payload_q <= q_data.is_payload;
			frame_done_q <= q_data.done;
			crc_ok_q <= ok_next;
			message_id_q <= q_data.message_id;
			payload_length_q <= q_data.payload_length;
			message_class_q <= q_data.message_class;
		end
	end

	assign out_valid = out_valid_q;
	assign echo_byte = echo_byte_q;
	assign in_frame = in_frame_q;
	assign frame_offset = frame_offset_q;
	assign is_payload = is_payload_q;
	assign frame_done = frame_done_q;
	assign crc_ok = crc_ok_q;
	assign message_id = message_id_q;
	assign payload_length = payload_length_q;
	assign message_class = message_class_q;

	`GBFCR_ASSERT(a_done_in_frame, (out_valid_q && frame_done_q) |-> (in_frame_q && !is_payload_q), "frame end outside frame or in payload")
	`GBFCR_ASSERT(a_ok_with_done, (out_valid_q && crc_ok_q) |-> frame_done_q, "crc_ok without frame end")

endmodule

`default_nettype wire

>>> sv/gnss_binary_frame_crc32_receiver.sv
// Binary GNSS frame receiver with CRC-32 check.
// Input channel: one received byte per transaction (in_valid, in_stall, data_byte).
// Output channel: one result per input byte (out_valid, out_stall and the result
// fields): the echoed byte, frame position flags and, on the last CRC byte, the
// CRC verdict with the captured message ID, payload length and message class.
// Configuration: crc_polynomial is loaded on any cycle with crc_polynomial_we high;
// write it only while no transaction is in flight.
// The result of an accepted byte is written into the queue and then into the output
// register. Throughput is one byte per cycle while the output is not stalled: the
// front end classifies a byte in the cycle it is taken, and the back end does a full
// eight-bit CRC update combinationally. A two-entry queue separates the two halves.
// When the output is stalled, the queue fills and in_stall rises once both queue
// entries are occupied; no result is lost or repeated.
// Reset clears the framing state, the queue and the output valid, and loads the
// polynomial 0xEDB88320. The block accepts input as soon as reset is released.
`default_nettype none

module gnss_binary_frame_crc32_receiver #(
	parameter int unsigned HEADER_BYTES = gbfcr_pkg::HEADER_BYTES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic crc_polynomial_we,
	input wire logic [31:0] crc_polynomial,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [7:0] data_byte,
	output logic out_valid,
	input wire logic out_stall,
	output logic [7:0] echo_byte,
	output logic in_frame,
	output logic [gbfcr_pkg::OffsetW-1:0] frame_offset,
	output logic is_payload,
	output logic frame_done,
	output logic crc_ok,
	output logic [15:0] message_id,
	output logic [15:0] payload_length,
	output logic [2:0] message_class
);
	import gbfcr_pkg::*;

	logic push;
	logic pop;
	logic q_full;
	logic q_empty;
	q_entry_t push_entry;
	q_entry_t pop_entry;

	// Sync hunt, header capture and byte classification.
	gbfcr_front #(
		.HEADER_BYTES(HEADER_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.q_full(q_full),
		.push(push),
		.entry(push_entry)
	);

	// Queue between classification and CRC evaluation.
	gbfcr_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_entry),
		.full(q_full),
		.pop(pop),
		.pop_data(pop_entry),
		.empty(q_empty)
	);

	// CRC evaluation and output register.
	gbfcr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.crc_polynomial_we(crc_polynomial_we),
		.crc_polynomial(crc_polynomial),
		.q_empty(q_empty),
		.q_data(pop_entry),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.echo_byte(echo_byte),
		.in_frame(in_frame),
		.frame_offset(frame_offset),
		.is_payload(is_payload),
		.frame_done(frame_done),
		.crc_ok(crc_ok),
		.message_id(message_id),
		.payload_length(payload_length),
		.message_class(message_class)
	);

endmodule

`default_nettype wire
